// ===== design/inode_byte_offset_mapper_top_macros.svh =====
// Assertion helpers for the inode byte offset mapper.
// Each macro expands to a labeled concurrent assertion in simulation
// and to nothing in synthesis.
`ifndef INODE_BYTE_OFFSET_MAPPER_TOP_MACROS_SVH
`define INODE_BYTE_OFFSET_MAPPER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high.
`define IBOM_ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
// Next-cycle implication, disabled while reset is high.
`define IBOM_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define IBOM_ASSERT_IMPLY(label, clk, rst, pre, post, msg)
`define IBOM_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

// ===== design/ibom_pkg.sv =====
package ibom_pkg;

   // Default sizes of the block store and the inode table.
   localparam int DEF_DISK_BLOCKS = 1024;
   localparam int DEF_INODE_COUNT = 256;

   // Fixed geometry of the file system.
   localparam int BLOCK_BYTES     = 256;
   localparam int OFFSET_W        = $clog2(BLOCK_BYTES);
   localparam int PTR_W           = 10;
   localparam int SIZE_W          = 21;
   localparam int POS_W           = 21;
   localparam int ADDR_W          = PTR_W + OFFSET_W;
   localparam int INODE_W         = 8;
   localparam int SLOT_W          = 4;
   localparam int WADDR_W         = 16;
   localparam int BNUM_W          = POS_W - OFFSET_W;
   localparam int SLOTS_PER_INODE = 10;
   localparam int SINGLE_SLOT     = 8;
   localparam int DOUBLE_SLOT     = 9;
   localparam int SIZE_SLOT       = 10;
   localparam int DIRECT_COUNT    = 8;
   localparam int SINGLE_LIMIT    = 72;
   localparam int WORDS_PER_BLOCK = 64;
   localparam int WORD_W          = $clog2(WORDS_PER_BLOCK);
   localparam int MAX_FILE_BLOCKS = 4168;
   localparam int MAX_FILE_BYTES  = MAX_FILE_BLOCKS * BLOCK_BYTES;

   // Request codes carried by a transaction.
   typedef enum logic [1:0] {
      REQ_WRITE_SLOT = 2'd0,
      REQ_WRITE_WORD = 2'd1,
      REQ_LOCATE     = 2'd2,
      REQ_NONE       = 2'd3
   } req_code_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_PAST_END  = 2'd1,
      STATUS_TOO_LARGE = 2'd2
   } status_type;

   // Program steps of the sequencer.
   typedef enum logic [2:0] {
      STEP_IDLE      = 3'd0,
      STEP_WR_SLOT   = 3'd1,
      STEP_WR_WORD   = 3'd2,
      STEP_LOC_READ  = 3'd3,
      STEP_LOC_CHECK = 3'd4,
      STEP_LOC_MID   = 3'd5,
      STEP_LOC_LEAF  = 3'd6,
      STEP_RESPOND   = 3'd7
   } step_type;

   // Datapath operations selected by a control word.
   typedef enum logic [2:0] {
      UOP_ACCEPT     = 3'd0,
      UOP_WRITE_SLOT = 3'd1,
      UOP_WRITE_WORD = 3'd2,
      UOP_READ_INODE = 3'd3,
      UOP_CHECK      = 3'd4,
      UOP_READ_LEAF  = 3'd5,
      UOP_TAKE_LEAF  = 3'd6,
      UOP_RESPOND    = 3'd7
   } uop_type;

   // Sequencing of the step counter.
   typedef enum logic [2:0] {
      JUMP_NEXT           = 3'd0,
      JUMP_GOTO           = 3'd1,
      JUMP_DISPATCH       = 3'd2,
      JUMP_IF_DONE        = 3'd3,
      JUMP_UNLESS_BLOCKED = 3'd4
   } jump_type;

   typedef struct packed {
      uop_type  uop;
      jump_type jump;
      step_type target;
   } ucode_type;

   // Control from the sequencer to the datapath.
   typedef struct packed {
      uop_type uop;
      logic    ready;
   } seq_ctrl_type;

   // Conditions from the datapath to the sequencer.
   typedef struct packed {
      logic         accept;
      req_code_type req_code;
      logic         done;
      logic         blocked;
   } dp_flags_type;

   // Microcode table: one control word per step.
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type word;
      unique case (step)
         STEP_IDLE:      word = '{UOP_ACCEPT,     JUMP_DISPATCH,       STEP_IDLE};
         STEP_WR_SLOT:   word = '{UOP_WRITE_SLOT, JUMP_GOTO,           STEP_RESPOND};
         STEP_WR_WORD:   word = '{UOP_WRITE_WORD, JUMP_GOTO,           STEP_RESPOND};
         STEP_LOC_READ:  word = '{UOP_READ_INODE, JUMP_NEXT,           STEP_IDLE};
         STEP_LOC_CHECK: word = '{UOP_CHECK,      JUMP_IF_DONE,        STEP_RESPOND};
         STEP_LOC_MID:   word = '{UOP_READ_LEAF,  JUMP_IF_DONE,        STEP_RESPOND};
         STEP_LOC_LEAF:  word = '{UOP_TAKE_LEAF,  JUMP_NEXT,           STEP_IDLE};
         STEP_RESPOND:   word = '{UOP_RESPOND,    JUMP_UNLESS_BLOCKED, STEP_IDLE};
         default:        word = '{UOP_ACCEPT,     JUMP_GOTO,           STEP_IDLE};
      endcase
      return word;
   endfunction

   // Entry point of the routine for each request code.
   function automatic step_type dispatch_step(input req_code_type code);
      step_type step;
      unique case (code)
         REQ_WRITE_SLOT: step = STEP_WR_SLOT;
         REQ_WRITE_WORD: step = STEP_WR_WORD;
         REQ_LOCATE:     step = STEP_LOC_READ;
         REQ_NONE:       step = STEP_RESPOND;
         default:        step = STEP_RESPOND;
      endcase
      return step;
   endfunction

endpackage

// ===== design/ibom_req_if.sv =====
interface ibom_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [7:0]  inode_index;
   logic [3:0]  slot_index;
   logic [15:0] word_address;
   logic [20:0] write_value;
   logic [20:0] position;

   modport source (
      output valid, req_type, inode_index, slot_index, word_address, write_value, position,
      input  ready
   );
   modport sink (
      input  valid, req_type, inode_index, slot_index, word_address, write_value, position,
      output ready
   );
endinterface

// ===== design/ibom_rsp_if.sv =====
interface ibom_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [17:0] byte_address;

   modport source (
      output valid, status, byte_address,
      input  ready
   );
   modport sink (
      input  valid, status, byte_address,
      output ready
   );
endinterface

// ===== design/inode_byte_offset_mapper_top.sv =====
// Inode byte offset mapper.
// The req_chan channel carries one request per transaction: a write of an
// inode slot (direct, single-indirect or double-indirect pointer, or file
// size), a write of a pointer word in the indirect block store, or a locate
// of a byte position in a file. Every request gives exactly one transaction
// on rsp_chan with a status and, for a successful locate, the byte address.
// A small microcode program steps one request at a time through the inode
// table and the pointer store, each a synchronous memory with one read per
// cycle. Writes go through their write step to the respond step, an unknown
// code straight to it. A locate reads the inode, then checks the size and,
// for a direct pointer, takes the address; a single-indirect block adds one
// pointer-store read and a double-indirect block two, each dependent on the
// one before. A new request can be accepted in the cycle after the result is
// loaded. The result sits in an output register: while the receiver stalls,
// the next request is still accepted and worked on, and the sequencer waits
// only when a second result is ready.
// Reset clears the sequencer, the output valid flag and the file sizes (all
// files read as empty); pointers must be written before they are followed.
`include "inode_byte_offset_mapper_top_macros.svh"

module inode_byte_offset_mapper_top #(
   parameter int DISK_BLOCKS = ibom_pkg::DEF_DISK_BLOCKS,
   parameter int INODE_COUNT = ibom_pkg::DEF_INODE_COUNT
) (
   input  logic        clock,
   input  logic        reset,
   ibom_req_if.sink    req_chan,
   ibom_rsp_if.source  rsp_chan
);
   import ibom_pkg::*;

   seq_ctrl_type seq_ctrl;
   dp_flags_type dp_flags;

   // Microcode sequencer.
   ibom_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (dp_flags),
      .ctrl  (seq_ctrl)
   );

   // Memories and working registers.
   ibom_dp #(
      .DISK_BLOCKS (DISK_BLOCKS),
      .INODE_COUNT (INODE_COUNT)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (seq_ctrl),
      .flags    (dp_flags),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Only one request is in flight at a time.
   `IBOM_ASSERT_NEXT(a_one_in_flight, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready, "request accepted while another is in flight")
   // A failed locate never reports an address.
   `IBOM_ASSERT_IMPLY(a_zero_addr_on_error, clock, reset, rsp_chan.valid && (rsp_chan.status != STATUS_OK), rsp_chan.byte_address == '0, "nonzero address with error status")
   // The respond step loads a valid result whenever the output is not blocked.
   `IBOM_ASSERT_NEXT(a_respond_loads, clock, reset, (seq_ctrl.uop == UOP_RESPOND) && !dp_flags.blocked, rsp_chan.valid, "respond step did not load a result")

endmodule

// ===== design/ibom_seq.sv =====
module ibom_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  ibom_pkg::dp_flags_type flags,
   output ibom_pkg::seq_ctrl_type ctrl
);
   import ibom_pkg::*;

   step_type  step_ff;
   step_type  step_in;
   ucode_type word;
   step_type  step_next;

   // Fetch the control word of the current step.
   always_comb begin
      word      = ucode_rom(step_ff);
      ctrl.uop   = word.uop;
      ctrl.ready = (word.uop == UOP_ACCEPT);
   end

   // Next step: fall through, jump, dispatch or hold.
   always_comb begin
      step_next = step_type'(step_ff + 3'd1);
      unique case (word.jump)
         JUMP_NEXT:           step_in = step_next;
         JUMP_GOTO:           step_in = word.target;
         JUMP_DISPATCH:       step_in = flags.accept ? dispatch_step(flags.req_code) : step_ff;
         JUMP_IF_DONE:        step_in = flags.done ? word.target : step_next;
         JUMP_UNLESS_BLOCKED: step_in = flags.blocked ? step_ff : word.target;
         default:             step_in = STEP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// ===== design/ibom_dp.sv =====
module ibom_dp #(
   parameter int DISK_BLOCKS = ibom_pkg::DEF_DISK_BLOCKS,
   parameter int INODE_COUNT = ibom_pkg::DEF_INODE_COUNT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ibom_pkg::seq_ctrl_type ctrl,
   output ibom_pkg::dp_flags_type flags,
   ibom_req_if.sink               req_chan,
   ibom_rsp_if.source             rsp_chan
);
   import ibom_pkg::*;

   // Only inodes reachable by the 8-bit index get storage.
   localparam int InodeDepth = (INODE_COUNT < (1 << INODE_W)) ? INODE_COUNT : (1 << INODE_W);
   localparam int SizeAw     = (InodeDepth > 1) ? $clog2(InodeDepth) : 1;
   localparam int PtrDepth   = InodeDepth * SLOTS_PER_INODE;
   localparam int PtrAw      = $clog2(PtrDepth);
   localparam int PtrIdxW    = $clog2((1 << INODE_W) * SLOTS_PER_INODE);
   localparam int StoreWords = DISK_BLOCKS * WORDS_PER_BLOCK;
   localparam int StoreDepth = (StoreWords < (1 << WADDR_W)) ? StoreWords : (1 << WADDR_W);
   localparam int StoreAw    = $clog2(StoreDepth);

   // Memories.
   logic [PTR_W-1:0]  ptr_mem [PtrDepth];
   logic [SIZE_W-1:0] size_mem [InodeDepth];
   logic [PTR_W-1:0]  store_mem [StoreDepth];
   logic [InodeDepth-1:0] size_valid_ff;

   // Latched request.
   logic [INODE_W-1:0] ino_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic [WADDR_W-1:0] waddr_ff;
   logic [SIZE_W-1:0]  value_ff;
   logic [POS_W-1:0]   pos_ff;

   // Read data and working registers.
   logic [PTR_W-1:0]   ptr_q_ff;
   logic [SIZE_W-1:0]  size_q_ff;
   logic [PTR_W-1:0]   store_q_ff;
   logic               store_ok_ff;
   logic               single_ff;
   status_type         status_ff;
   logic [ADDR_W-1:0]  addr_ff;

   // Output register.
   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic [ADDR_W-1:0]  rsp_addr_ff;

   logic               accept;
   logic               done;
   logic               ino_ok;
   logic [BNUM_W-1:0]  bnum;
   logic [OFFSET_W-1:0] boff;
   logic [BNUM_W-1:0]  rel;
   logic [WORD_W-1:0]  sword;
   logic               is_direct;
   logic               is_single;
   logic               past_end;
   logic               too_large;
   logic [SLOT_W-1:0]  rd_slot;
   logic [SLOT_W-1:0]  slot_sel;
   logic [PtrIdxW-1:0] ptr_idx;
   logic [SizeAw-1:0]  size_idx;
   logic [PTR_W-1:0]   leaf;
   logic [WADDR_W-1:0] st_raddr;
   logic               st_rd_ok;
   logic               st_wr_ok;

   // Handshake and flags for the sequencer.
   assign accept         = ctrl.ready && req_chan.valid;
   assign req_chan.ready = ctrl.ready;
   assign flags.accept   = accept;
   assign flags.req_code = req_code_type'(req_chan.req_type);
   assign flags.done     = done;
   assign flags.blocked  = rsp_valid_ff && !rsp_chan.ready;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.byte_address = rsp_addr_ff;

   // Decode of the file position.
   always_comb begin
      ino_ok    = (32'(ino_ff) < INODE_COUNT);
      bnum      = pos_ff[POS_W-1:OFFSET_W];
      boff      = pos_ff[OFFSET_W-1:0];
      rel       = bnum - BNUM_W'(SINGLE_LIMIT);
      sword     = WORD_W'(bnum - BNUM_W'(DIRECT_COUNT));
      is_direct = (bnum < BNUM_W'(DIRECT_COUNT));
      is_single = (bnum < BNUM_W'(SINGLE_LIMIT));
      past_end  = (pos_ff >= size_q_ff);
      too_large = (size_q_ff > SIZE_W'(MAX_FILE_BYTES));
      leaf      = store_ok_ff ? store_q_ff : '0;
   end

   // Inode table addressing: direct slot, single or double indirect slot.
   always_comb begin
      if (is_direct) begin
         rd_slot = SLOT_W'(bnum);
      end else if (is_single) begin
         rd_slot = SLOT_W'(SINGLE_SLOT);
      end else begin
         rd_slot = SLOT_W'(DOUBLE_SLOT);
      end
      slot_sel = (ctrl.uop == UOP_WRITE_SLOT) ? slot_ff : rd_slot;
      ptr_idx  = PtrIdxW'(PtrIdxW'(ino_ff) * PtrIdxW'(SLOTS_PER_INODE) + PtrIdxW'(slot_sel));
      size_idx = ino_ff[SizeAw-1:0];
   end

   // Pointer store read address: first level from the inode, second from the store.
   always_comb begin
      if (ctrl.uop == UOP_CHECK) begin
         st_raddr = {ptr_q_ff, (is_single ? sword : rel[2*WORD_W-1:WORD_W])};
      end else begin
         st_raddr = {leaf, rel[WORD_W-1:0]};
      end
      st_rd_ok = (32'(st_raddr) < StoreWords);
      st_wr_ok = (32'(waddr_ff) < StoreWords);
   end

   // Completion condition for conditional jumps.
   always_comb begin
      case (ctrl.uop)
         UOP_CHECK:     done = past_end || too_large || is_direct;
         UOP_READ_LEAF: done = single_ff;
         default:       done = 1'b0;
      endcase
   end

   // Request latch, result computation and memory writes.
   always_ff @(posedge clock) begin
      case (ctrl.uop)
         UOP_ACCEPT: begin
            if (accept) begin
               ino_ff    <= req_chan.inode_index;
               slot_ff   <= req_chan.slot_index;
               waddr_ff  <= req_chan.word_address;
               value_ff  <= req_chan.write_value;
               pos_ff    <= req_chan.position;
               status_ff <= STATUS_OK;
               addr_ff   <= '0;
            end
         end
         UOP_WRITE_SLOT: begin
            if (ino_ok && (slot_ff < SLOT_W'(SLOTS_PER_INODE))) begin
               ptr_mem[ptr_idx[PtrAw-1:0]] <= value_ff[PTR_W-1:0];
            end else if (ino_ok && (slot_ff == SLOT_W'(SIZE_SLOT))) begin
               size_mem[size_idx] <= value_ff;
            end
         end
         UOP_WRITE_WORD: begin
            if (st_wr_ok) begin
               store_mem[waddr_ff[StoreAw-1:0]] <= value_ff[PTR_W-1:0];
            end
         end
         UOP_READ_INODE: begin
            ptr_q_ff  <= ptr_mem[ptr_idx[PtrAw-1:0]];
            size_q_ff <= (ino_ok && size_valid_ff[size_idx]) ? size_mem[size_idx] : '0;
         end
         UOP_CHECK: begin
            single_ff   <= is_single;
            store_q_ff  <= store_mem[st_raddr[StoreAw-1:0]];
            store_ok_ff <= st_rd_ok;
            if (past_end) begin
               status_ff <= STATUS_PAST_END;
            end else if (too_large) begin
               status_ff <= STATUS_TOO_LARGE;
            end else if (is_direct) begin
               addr_ff <= {ptr_q_ff, boff};
            end
         end
         UOP_READ_LEAF: begin
            store_q_ff  <= store_mem[st_raddr[StoreAw-1:0]];
            store_ok_ff <= st_rd_ok;
            if (single_ff) begin
               addr_ff <= {leaf, boff};
            end
         end
         UOP_TAKE_LEAF: begin
            addr_ff <= {leaf, boff};
         end
         default: begin
         end
      endcase
   end

   // Size entries read as zero until written.
   always_ff @(posedge clock) begin
      if (reset) begin
         size_valid_ff <= '0;
      end else if ((ctrl.uop == UOP_WRITE_SLOT) && ino_ok
                   && (slot_ff == SLOT_W'(SIZE_SLOT))) begin
         size_valid_ff[size_idx] <= 1'b1;
      end
   end

   // Output register: loaded at the respond step, cleared when taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((ctrl.uop == UOP_RESPOND) && !flags.blocked) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((ctrl.uop == UOP_RESPOND) && !flags.blocked) begin
         rsp_status_ff <= status_ff;
         rsp_addr_ff   <= addr_ff;
      end
   end

endmodule
